// ===== src/palette_lookup_upscaler_2x_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for palette_lookup_upscaler_2x_top
// Clocked assertion forms shared by the checker.
// ----------------------------------------------------------------------------
`ifndef PALETTE_LOOKUP_UPSCALER_2X_TOP_MACROS_SVH
`define PALETTE_LOOKUP_UPSCALER_2X_TOP_MACROS_SVH

// Check a property while out of reset.
`define PLU2X_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define PLU2X_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/plu2x_pkg.sv =====
// ----------------------------------------------------------------------------
// plu2x_pkg
// Frame geometry, field widths, command codes and color packing.
// ----------------------------------------------------------------------------
package plu2x_pkg;

    localparam int SRC_WIDTH     = 160;
    localparam int SRC_HEIGHT    = 120;
    localparam int PALETTE_DEPTH = 256;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 8;
    localparam int COLOR_W  = 24;
    localparam int PIX_W    = 16;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 2 * PIX_W;
    localparam int CNT_W    = 9;
    localparam int COL_W    = $clog2(SRC_WIDTH);
    localparam int ROW_W    = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
    localparam int PAL_AW   = $clog2(PALETTE_DEPTH);

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(256);

    typedef enum logic [CMD_W-1:0] {
        CMD_PAL_WRITE = 2'd0,
        CMD_PIXEL     = 2'd1,
        CMD_RESTART   = 2'd2
    } t_cmd;

    function automatic logic [PIX_W-1:0] rgb_to_565(input logic [COLOR_W-1:0] c);
        rgb_to_565 = {c[7:3], c[15:10], c[23:19]};
    endfunction

endpackage

// ===== src/plu2x_ifs.sv =====
// ----------------------------------------------------------------------------
// plu2x channel interfaces
// Request, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface plu2x_pix_if;
    logic                       valid;
    logic                       ready;
    logic [plu2x_pkg::CMD_W-1:0]   command;
    logic [plu2x_pkg::IDX_W-1:0]   pixel_index;
    logic [plu2x_pkg::COLOR_W-1:0] color_value;

    modport source (output valid, command, pixel_index, color_value, input ready);
    modport sink   (input valid, command, pixel_index, color_value, output ready);
endinterface

interface plu2x_word_if;
    logic                         valid;
    logic                         ready;
    logic [plu2x_pkg::ADDR_W-1:0] word_address;
    logic [plu2x_pkg::DATA_W-1:0] word_data;
    logic                         bad_index;
    logic                         last;
    logic                         frame_end;

    modport source (output valid, word_address, word_data, bad_index, last, frame_end,
                    input ready);
    modport sink   (input valid, word_address, word_data, bad_index, last, frame_end,
                    output ready);
endinterface

interface plu2x_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [plu2x_pkg::CNT_W-1:0] color_count;

    modport source (output valid, color_count, input ready);
    modport sink   (input valid, color_count, output ready);
endinterface

// ===== src/plu2x_ram.sv =====
// ----------------------------------------------------------------------------
// plu2x_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plu2x_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/palette_lookup_upscaler_2x_top.sv =====
// ----------------------------------------------------------------------------
// palette_lookup_upscaler_2x_top
// Palette lookup with 2x nearest-neighbor upscale to 5-6-5 word pairs.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix carries requests: palette write, source pixel or position restart.
//   i_cfg writes color_count (reset 256); write it only while idle.
//   o_word carries results: each pixel gives two words, the upper-row word
//   (last = 0) and then the lower-row word (last = 1), 160 words apart.
//   A palette write or restart gives no result. A taken pixel request
//   waits in the lookup stage while the palette is read, then its upper
//   word is registered in the result register; the lower word follows in
//   the cycle after the upper word is taken. The single result port emits
//   two words per pixel, and one more pixel can wait in the lookup stage
//   meanwhile; palette writes and restarts go at one per cycle while no
//   pixel waits in the lookup stage. The palette is a 256 x 16 RAM with
//   registered reads; a write then a read of one entry needs no interlock.
//   Reset clears the position to the frame origin, color_count to 256 and
//   the pipeline to empty; palette contents are undefined until written.
//   When the receiver stalls, the shown word holds, one more pixel waits in
//   the lookup stage and i_pix.ready then drops.
// ----------------------------------------------------------------------------
module palette_lookup_upscaler_2x_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    plu2x_pix_if.sink       i_pix,
    plu2x_cfg_if.sink       i_cfg,
    plu2x_word_if.source    o_word
);
    import plu2x_pkg::*;

    t_cmd               w_cmd;
    logic               w_in_ready;
    logic               w_in_fire;
    logic               w_pix_fire;
    logic               w_wr_fire;
    logic               w_wr_en;
    logic               w_out_fire;
    logic               w_s2_free;
    logic               w_bad;
    logic               w_col_end;
    logic               w_fend;
    logic [CNT_W-1:0]   w_limit;
    logic [PIX_W-1:0]   w_rd;

    logic [CNT_W-1:0]   r_color_count;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [ADDR_W-1:0]  r_row_base;

    logic               r_s1_valid;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic               r_s1_bad;
    logic               r_s1_fend;

    logic               r_out_valid;
    logic               r_out_last;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [DATA_W-1:0]  r_out_data;
    logic               r_out_bad;
    logic               r_out_fend;

    assign w_cmd      = t_cmd'(i_pix.command);
    assign w_out_fire = r_out_valid && o_word.ready;
    assign w_s2_free  = !r_out_valid || (w_out_fire && r_out_last);
    assign w_in_ready = !r_s1_valid || w_s2_free;
    assign w_in_fire  = i_pix.valid && w_in_ready;
    assign w_pix_fire = w_in_fire && (w_cmd == CMD_PIXEL);
    assign w_wr_fire  = w_in_fire && (w_cmd == CMD_PAL_WRITE);
    assign w_wr_en    = w_wr_fire &&
                        (CNT_W'(i_pix.pixel_index) < CNT_W'(PALETTE_DEPTH));

    assign w_limit   = (r_color_count < CNT_W'(PALETTE_DEPTH)) ? r_color_count
                                                                : CNT_W'(PALETTE_DEPTH);
    assign w_bad     = CNT_W'(i_pix.pixel_index) >= w_limit;
    assign w_col_end = r_col == COL_W'(SRC_WIDTH - 1);
    assign w_fend    = w_col_end && (r_row == ROW_W'(SRC_HEIGHT - 1));

    assign i_pix.ready = w_in_ready;
    assign i_cfg.ready = 1'b1;

    plu2x_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (i_pix.pixel_index[PAL_AW-1:0]),
        .i_wdata (rgb_to_565(i_pix.color_value)),
        .i_re    (w_pix_fire),
        .i_raddr (i_pix.pixel_index[PAL_AW-1:0]),
        .o_rdata (w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_count <= CNT_RESET;
        end else if (i_cfg.valid) begin
            r_color_count <= i_cfg.color_count;
        end
    end

    // Advance the source position on each pixel, wrap at frame end; a restart returns it to the origin.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_row_base <= '0;
        end else if (w_in_fire) begin
            case (w_cmd)
                CMD_RESTART: begin
                    r_col      <= '0;
                    r_row      <= '0;
                    r_row_base <= '0;
                end
                CMD_PIXEL: begin
                    if (w_col_end) begin
                        r_col <= '0;
                        if (r_row == ROW_W'(SRC_HEIGHT - 1)) begin
                            r_row      <= '0;
                            r_row_base <= '0;
                        end else begin
                            r_row      <= r_row + ROW_W'(1);
                            r_row_base <= r_row_base + ADDR_W'(2 * SRC_WIDTH);
                        end
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Lookup stage: hold while the result register is busy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_pix_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s2_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pix_fire) begin
            r_s1_addr <= r_row_base + ADDR_W'(r_col);
            r_s1_bad  <= w_bad;
            r_s1_fend <= w_fend;
        end
    end

    // Result register: upper word, then lower word one row below.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else if (r_s1_valid && w_s2_free) begin
            r_out_valid <= 1'b1;
            r_out_last  <= 1'b0;
        end else if (w_out_fire) begin
            r_out_valid <= !r_out_last;
            r_out_last  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_s2_free) begin
            r_out_addr <= r_s1_addr;
            r_out_data <= r_s1_bad ? '0 : {w_rd, w_rd};
            r_out_bad  <= r_s1_bad;
            r_out_fend <= r_s1_fend;
        end else if (w_out_fire && !r_out_last) begin
            r_out_addr <= r_out_addr + ADDR_W'(SRC_WIDTH);
        end
    end

    assign o_word.valid        = r_out_valid;
    assign o_word.word_address = r_out_addr;
    assign o_word.word_data    = r_out_data;
    assign o_word.bad_index    = r_out_bad;
    assign o_word.last         = r_out_last;
    assign o_word.frame_end    = r_out_fend;

endmodule

// ===== src/plu2x_checker.sv =====
// ----------------------------------------------------------------------------
// plu2x_checker
// Port-level checks on the result channel of the upscaler.
// ----------------------------------------------------------------------------
`include "palette_lookup_upscaler_2x_top_macros.svh"

module plu2x_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [plu2x_pkg::ADDR_W-1:0] i_out_addr,
    input  logic [plu2x_pkg::DATA_W-1:0] i_out_data,
    input  logic                         i_out_bad,
    input  logic                         i_out_last,
    input  logic                         i_out_fend
);
    import plu2x_pkg::*;

    `PLU2X_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_addr) && $stable(i_out_data), "result changed while stalled")
    `PLU2X_ASSERT(a_pair, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last |=> i_out_valid && i_out_last && (i_out_addr == $past(i_out_addr) + ADDR_W'(SRC_WIDTH)) && (i_out_data == $past(i_out_data)) && (i_out_fend == $past(i_out_fend)), "lower word does not match upper word")
    `PLU2X_ASSERT(a_bad_zero, i_clk, i_rst_n, i_out_valid && i_out_bad |-> i_out_data == '0, "bad index with nonzero data")
    `PLU2X_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind palette_lookup_upscaler_2x_top plu2x_checker u_plu2x_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_word.valid),
    .i_out_ready (o_word.ready),
    .i_out_addr  (o_word.word_address),
    .i_out_data  (o_word.word_data),
    .i_out_bad   (o_word.bad_index),
    .i_out_last  (o_word.last),
    .i_out_fend  (o_word.frame_end)
);
